// File: rtl/core/shrp_pkg.sv
// ----------------------------------------------------------------------------
// shrp_pkg: shared types and constants of the sensor-hub report parser
// Result item layout, push bundle and the fixed codes of the transport format.
// ----------------------------------------------------------------------------
package shrp_pkg;

  localparam int unsigned HdrBytes      = 4;
  localparam logic [7:0]  IdTimestamp   = 8'hFB;
  localparam logic [7:0]  IdRotation    = 8'h05;
  localparam int unsigned TimestampLen  = 5;
  localparam int unsigned RotationLen   = 14;
  localparam int unsigned RotPayloadOfs = 4;
  localparam int unsigned FieldBytes    = 10;

  localparam logic KindReport = 1'b0;
  localparam logic KindEnd    = 1'b1;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = 2;
  localparam int unsigned CntW      = 3;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] quat_i;
    logic signed [15:0] quat_j;
    logic signed [15:0] quat_k;
    logic signed [15:0] quat_real;
    logic signed [15:0] accuracy_q12;
    logic               any_found;
    logic               last;
  } result_t;

  // up to two result items written in one cycle, item0 first
  typedef struct packed {
    logic [1:0] cnt;
    result_t    item0;
    result_t    item1;
  } push_t;

endpackage

// File: rtl/core/shrp_res_fifo.sv
// ----------------------------------------------------------------------------
// shrp_res_fifo: result queue of the report parser
// Four-entry queue that takes up to two result items per cycle and hands
// out one per cycle on a valid/stall channel.
// ----------------------------------------------------------------------------
module shrp_res_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  shrp_pkg::push_t   push_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output shrp_pkg::result_t out_item_o
);

  shrp_pkg::result_t               mem_q [shrp_pkg::FifoDepth];
  logic [shrp_pkg::PtrW-1:0]       wr_q, wr_d;
  logic [shrp_pkg::PtrW-1:0]       rd_q, rd_d;
  logic [shrp_pkg::CntW-1:0]       cnt_q, cnt_d;
  logic                            pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  // two free entries guarantee room for the two items of a worst-case byte
  assign room_o      = (cnt_q <= shrp_pkg::CntW'(shrp_pkg::FifoDepth - 2));

  always_comb begin
    wr_d  = wr_q + shrp_pkg::PtrW'(push_i.cnt);
    rd_d  = pop ? rd_q + shrp_pkg::PtrW'(1) : rd_q;
    cnt_d = cnt_q + shrp_pkg::CntW'(push_i.cnt) - shrp_pkg::CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.item0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_q + shrp_pkg::PtrW'(1)] <= push_i.item1;
    end
  end

endmodule

// File: rtl/core/sensor_hub_report_parser_core.sv
// ----------------------------------------------------------------------------
// sensor_hub_report_parser_core: rotation-vector report parser
// Walks the records of one transport packet byte by byte and reports the raw
// quaternion and accuracy of each rotation-vector record, plus an end item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one packet byte per item (packet_byte_i, first_byte_i) on
//   in_valid_i / in_stall_o. first_byte_i restarts parsing at any time.
//   Output channel: result items on out_valid_o / out_stall_i; kind_o tells a
//   rotation report from the end-of-packet item, last_o marks the final
//   result caused by one input byte.
//   A byte is parsed in the cycle it is accepted against the header/record
//   state registers; its results are registered in a four-entry result queue
//   that drives the outputs. One byte is taken every cycle while the
//   queue holds two or fewer items; a byte yields at most two results, so
//   with the receiver ready the rate is one byte per cycle, and the queue
//   drain rate (one result per cycle) sets the figure otherwise.
//   While the receiver stalls, queued items hold and in_stall_o rises once
//   three items wait. Reset empties the queue and leaves the parser idle,
//   ignoring bytes until one arrives with first_byte_i set.
// ----------------------------------------------------------------------------
module sensor_hub_report_parser_core #(
  parameter int unsigned MAX_PACKET = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         packet_byte_i,
  input  logic               first_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic signed [15:0] quat_i_o,
  output logic signed [15:0] quat_j_o,
  output logic signed [15:0] quat_k_o,
  output logic signed [15:0] quat_real_o,
  output logic signed [15:0] accuracy_q12_o,
  output logic               any_found_o,
  output logic               last_o
);

  localparam int unsigned PW = $clog2(MAX_PACKET + 1);

  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] len_q, len_d;
  logic [7:0]    len_lo_q, len_lo_d;
  logic [PW-1:0] rs_q, rs_d;
  logic          rot_q, rot_d;
  logic          found_q, found_d;
  logic          stopped_q, stopped_d;
  logic [7:0]    field_q [shrp_pkg::FieldBytes];

  logic              room;
  logic              accept;
  logic [14:0]       hdr_len;
  logic [PW-1:0]     cargo_pos;
  logic [PW-1:0]     cargo_len;
  logic [PW-1:0]     rec_off;
  logic              field_we;
  logic              rpt;
  logic              pkt_end;
  shrp_pkg::result_t rpt_item;
  shrp_pkg::result_t end_item;
  shrp_pkg::push_t   push;
  shrp_pkg::result_t out_item;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;
  assign hdr_len    = {packet_byte_i[6:0], len_lo_q};
  assign cargo_pos  = pos_q - PW'(shrp_pkg::HdrBytes);
  assign cargo_len  = len_q - PW'(shrp_pkg::HdrBytes);
  assign rec_off    = cargo_pos - rs_q;

  always_comb begin
    pos_d     = pos_q;
    len_d     = len_q;
    len_lo_d  = len_lo_q;
    rs_d      = rs_q;
    rot_d     = rot_q;
    found_d   = found_q;
    stopped_d = stopped_q;
    field_we  = 1'b0;
    rpt       = 1'b0;
    pkt_end   = 1'b0;

    if (accept) begin
      priority if (first_byte_i) begin
        len_lo_d  = packet_byte_i;
        pos_d     = PW'(1);
        len_d     = '0;
        rs_d      = '0;
        rot_d     = 1'b0;
        found_d   = 1'b0;
        stopped_d = 1'b0;
      end else if (pos_q == '0) begin
        // idle: stray byte ignored
      end else if (pos_q == PW'(1)) begin
        if (hdr_len <= 15'(shrp_pkg::HdrBytes)) begin
          pos_d     = '0;
          stopped_d = 1'b1;
        end else begin
          len_d = (hdr_len > 15'(MAX_PACKET)) ? PW'(MAX_PACKET) : hdr_len[PW-1:0];
          pos_d = PW'(2);
        end
      end else if (pos_q < PW'(shrp_pkg::HdrBytes)) begin
        pos_d = pos_q + PW'(1);
      end else begin
        if (!stopped_q) begin
          if (!rot_q && cargo_pos == rs_q) begin
            priority if ({1'b0, rs_q} + (PW+1)'(1) >= {1'b0, cargo_len}) begin
              stopped_d = 1'b1;
            end else if (packet_byte_i == shrp_pkg::IdTimestamp) begin
              rs_d = rs_q + PW'(shrp_pkg::TimestampLen);
            end else if (packet_byte_i == shrp_pkg::IdRotation &&
                         {1'b0, rs_q} + (PW+1)'(shrp_pkg::RotationLen)
                           <= {1'b0, cargo_len}) begin
              rot_d = 1'b1;
            end else begin
              stopped_d = 1'b1;
            end
          end else if (rot_q) begin
            field_we = 1'b1;
            if (rec_off == PW'(shrp_pkg::RotationLen - 1)) begin
              rpt     = 1'b1;
              found_d = 1'b1;
              rs_d    = rs_q + PW'(shrp_pkg::RotationLen);
              rot_d   = 1'b0;
            end
          end
        end
        if (pos_q + PW'(1) == len_q) begin
          pkt_end   = 1'b1;
          pos_d     = '0;
          stopped_d = 1'b1;
          rot_d     = 1'b0;
        end else begin
          pos_d = pos_q + PW'(1);
        end
      end
    end
  end

  always_comb begin
    rpt_item              = '0;
    rpt_item.kind         = shrp_pkg::KindReport;
    rpt_item.quat_i       = {field_q[1], field_q[0]};
    rpt_item.quat_j       = {field_q[3], field_q[2]};
    rpt_item.quat_k       = {field_q[5], field_q[4]};
    rpt_item.quat_real    = {field_q[7], field_q[6]};
    // the top accuracy byte is the one arriving now
    rpt_item.accuracy_q12 = {packet_byte_i, field_q[8]};
    rpt_item.last         = !pkt_end;

    end_item           = '0;
    end_item.kind      = shrp_pkg::KindEnd;
    end_item.any_found = found_d;
    end_item.last      = 1'b1;

    push       = '0;
    push.cnt   = 2'(rpt) + 2'(pkt_end);
    push.item0 = rpt ? rpt_item : end_item;
    push.item1 = end_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      len_q     <= '0;
      len_lo_q  <= '0;
      rs_q      <= '0;
      rot_q     <= 1'b0;
      found_q   <= 1'b0;
      stopped_q <= 1'b1;
    end else begin
      pos_q     <= pos_d;
      len_q     <= len_d;
      len_lo_q  <= len_lo_d;
      rs_q      <= rs_d;
      rot_q     <= rot_d;
      found_q   <= found_d;
      stopped_q <= stopped_d;
    end
  end

  for (genvar k = 0; k < shrp_pkg::FieldBytes; k++) begin : g_field
    always_ff @(posedge clk_i) begin
      if (field_we && rec_off == PW'(k + shrp_pkg::RotPayloadOfs)) begin
        field_q[k] <= packet_byte_i;
      end
    end
  end

  shrp_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item)
  );

  assign kind_o         = out_item.kind;
  assign quat_i_o       = out_item.quat_i;
  assign quat_j_o       = out_item.quat_j;
  assign quat_k_o       = out_item.quat_k;
  assign quat_real_o    = out_item.quat_real;
  assign accuracy_q12_o = out_item.accuracy_q12;
  assign any_found_o    = out_item.any_found;
  assign last_o         = out_item.last;

  // a double result is always a report followed by the end item
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.cnt == 2'd2 |-> push.item0.kind == shrp_pkg::KindReport && !push.item0.last)
    else $error("double result not report then end");

  // the end item always returns the parser to idle
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_end |=> pos_q == '0)
    else $error("parser not idle after end item");

  // once past the length header, the position stays inside the packet
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q > PW'(1) |-> pos_q < len_q)
    else $error("byte position beyond packet length");

  // a rotation record is only collected while parsing runs
  a_rot_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot_q |-> !stopped_q)
    else $error("rotation collection while parsing stopped");

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the sensor-hub report parser core
// Feeds transport packets byte by byte, mostly well-formed record streams with
// random content plus short, restarted, overlong and noisy packets, predicts
// every report and end item, and checks each result item in order while both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned MaxPacket   = 64;
  localparam int unsigned HoldLen     = 150;
  localparam int unsigned EndWait     = 16;
  localparam int unsigned LimitCycles = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_stall_o;
  logic [7:0] packet_byte = 8'h00;
  logic       first_byte = 1'b0;
  logic       out_valid_o;
  logic       out_stall = 1'b0;
  logic       kind_o;
  logic signed [15:0] quat_i_o, quat_j_o, quat_k_o, quat_real_o, accuracy_q12_o;
  logic       any_found_o;
  logic       last_o;

  sensor_hub_report_parser_core #(
    .MAX_PACKET(MaxPacket)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .packet_byte_i (packet_byte),
    .first_byte_i  (first_byte),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .kind_o        (kind_o),
    .quat_i_o      (quat_i_o),
    .quat_j_o      (quat_j_o),
    .quat_k_o      (quat_k_o),
    .quat_real_o   (quat_real_o),
    .accuracy_q12_o(accuracy_q12_o),
    .any_found_o   (any_found_o),
    .last_o        (last_o)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // parser state as seen by the predictor
  logic [6:0] byte_pos;
  logic [6:0] pkt_len;
  logic [7:0] len_low;
  logic [6:0] rec_start;
  logic       collecting;
  logic [7:0] rot_bytes [shrp_pkg::FieldBytes];
  logic       seen_report;
  logic       walk_stopped;

  shrp_pkg::result_t due_items [$];
  shrp_pkg::result_t want, got;
  logic [7:0]        pkt [$];

  int unsigned items_sent = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_pct = 0;
  int unsigned recv_pct = 0;

  logic        hold_tog = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;

  // works out the result items that one accepted byte causes
  task automatic track_byte(input logic [7:0] b, input logic f);
    logic [14:0]       len_field;
    int unsigned       p, c, n, off;
    shrp_pkg::result_t rep, fin;
    bit                has_rep;
    has_rep = 1'b0;
    rep = '0;
    if (f) begin
      len_low = b;
      byte_pos = 7'd1;
      pkt_len = '0;
      rec_start = '0;
      collecting = 1'b0;
      seen_report = 1'b0;
      walk_stopped = 1'b0;
      return;
    end
    if (byte_pos == 7'd0) return;
    p = 32'(byte_pos);
    if (p == 1) begin
      len_field = {b[6:0], len_low};
      if (len_field <= 15'(shrp_pkg::HdrBytes)) begin
        byte_pos = 7'd0;
        walk_stopped = 1'b1;
        return;
      end
      if (len_field > 15'(MaxPacket)) len_field = 15'(MaxPacket);
      pkt_len = len_field[6:0];
      byte_pos = 7'd2;
      return;
    end
    if (p < shrp_pkg::HdrBytes) begin
      byte_pos = 7'(p + 1);
      return;
    end
    c = p - shrp_pkg::HdrBytes;
    n = 32'(pkt_len) - shrp_pkg::HdrBytes;
    if (!walk_stopped) begin
      if (!collecting && c == 32'(rec_start)) begin
        if (32'(rec_start) + 1 >= n) begin
          walk_stopped = 1'b1;
        end else if (b == shrp_pkg::IdTimestamp) begin
          rec_start = 7'(32'(rec_start) + shrp_pkg::TimestampLen);
        end else if (b == shrp_pkg::IdRotation &&
                     32'(rec_start) + shrp_pkg::RotationLen <= n) begin
          collecting = 1'b1;
        end else begin
          walk_stopped = 1'b1;
        end
      end else if (collecting) begin
        off = c - 32'(rec_start);
        if (off >= shrp_pkg::RotPayloadOfs && off < shrp_pkg::RotationLen)
          rot_bytes[4'(off - shrp_pkg::RotPayloadOfs)] = b;
        if (off == shrp_pkg::RotationLen - 1) begin
          rep.kind = shrp_pkg::KindReport;
          rep.quat_i = {rot_bytes[1], rot_bytes[0]};
          rep.quat_j = {rot_bytes[3], rot_bytes[2]};
          rep.quat_k = {rot_bytes[5], rot_bytes[4]};
          rep.quat_real = {rot_bytes[7], rot_bytes[6]};
          rep.accuracy_q12 = {rot_bytes[9], rot_bytes[8]};
          has_rep = 1'b1;
          seen_report = 1'b1;
          rec_start = 7'(32'(rec_start) + shrp_pkg::RotationLen);
          collecting = 1'b0;
        end
      end
    end
    if (p + 1 == 32'(pkt_len)) begin
      fin = '0;
      fin.kind = shrp_pkg::KindEnd;
      fin.any_found = seen_report;
      fin.last = 1'b1;
      if (has_rep) due_items.push_back(rep);
      due_items.push_back(fin);
      byte_pos = 7'd0;
      walk_stopped = 1'b1;
      collecting = 1'b0;
    end else begin
      if (has_rep) begin
        rep.last = 1'b1;
        due_items.push_back(rep);
      end
      byte_pos = 7'(p + 1);
    end
  endtask

  // offers one item, holds it until taken, then predicts its results
  task automatic send_item(input logic [7:0] b, input logic f);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    packet_byte <= b;
    first_byte <= f;
    do @(posedge clk); while (in_stall_o);
    items_sent++;
    track_byte(b, f);
  endtask

  task automatic send_pkt(input int unsigned cnt);
    for (int unsigned i = 0; i < cnt; i++) send_item(pkt[i], i == 0);
  endtask

  // builds a packet into pkt: a record stream, cut by a random or exact length
  task automatic build_packet(input bit dense);
    logic [7:0]  cargo [$];
    logic [14:0] len_field;
    int unsigned goal, total, body, r;
    bit          long_len, cbit;
    cargo = {};
    goal = dense ? 42 : $urandom_range(60, 1);
    while (cargo.size() < goal) begin
      r = $urandom_range(99);
      if (dense || r < 55) begin
        cargo.push_back(shrp_pkg::IdRotation);
        repeat (13) cargo.push_back(8'($urandom_range(255)));
      end else if (r < 90) begin
        cargo.push_back(shrp_pkg::IdTimestamp);
        repeat (4) cargo.push_back(8'($urandom_range(255)));
      end else begin
        cargo.push_back(8'($urandom_range(255)));
        repeat ($urandom_range(6)) cargo.push_back(8'($urandom_range(255)));
      end
    end
    if (dense || $urandom_range(99) < 50) begin
      total = cargo.size() + shrp_pkg::HdrBytes;
      if (total > MaxPacket) total = MaxPacket;
    end else begin
      total = $urandom_range(MaxPacket, 5);
    end
    len_field = 15'(total);
    long_len = !dense && ($urandom_range(99) < 10);
    if (long_len) len_field = 15'($urandom_range(32767, MaxPacket + 1));
    body = long_len ? MaxPacket - shrp_pkg::HdrBytes : total - shrp_pkg::HdrBytes;
    cbit = 1'($urandom_range(1));
    pkt = {};
    pkt.push_back(len_field[7:0]);
    pkt.push_back({cbit, len_field[14:8]});
    pkt.push_back(8'($urandom_range(255)));
    pkt.push_back(8'($urandom_range(255)));
    for (int unsigned i = 0; i < body; i++)
      pkt.push_back((i < cargo.size()) ? cargo[i] : 8'($urandom_range(255)));
    // bytes past the clamped end are ignored
    if (long_len) repeat ($urandom_range(4, 1)) pkt.push_back(8'($urandom_range(255)));
  endtask

  task automatic test_idle_and_short;
    send_item(8'hA5, 1'b0);
    send_item(8'h04, 1'b1);
    send_item(8'h00, 1'b0);
  endtask

  task automatic test_restart;
    send_item(8'h30, 1'b1);
    send_item(8'h00, 1'b0);
  endtask

  // rotation record that exactly fills the cargo, extreme field values
  task automatic test_extreme_report;
    pkt = {8'h12, 8'h80, 8'hFF, 8'h00,
           shrp_pkg::IdRotation, 8'hFF, 8'h00, 8'hAA,
           8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h01, 8'h00};
    send_pkt(pkt.size());
  endtask

  task automatic test_drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_items.size() != 0) @(posedge clk);
  endtask

  task automatic test_random_traffic(input int unsigned snd, input int unsigned rcv,
                                     input int unsigned nbytes);
    int unsigned goal, r;
    logic [7:0]  len_lo;
    bit          cbit;
    send_pct = snd;
    recv_pct = rcv;
    goal = items_sent + nbytes;
    while (items_sent < goal) begin
      r = $urandom_range(99);
      if (r < 70) begin
        build_packet(1'b0);
        send_pkt(pkt.size());
      end else if (r < 80) begin
        // length of four or less, dropped
        len_lo = 8'($urandom_range(shrp_pkg::HdrBytes));
        cbit = 1'($urandom_range(1));
        send_item(len_lo, 1'b1);
        send_item({cbit, 7'd0}, 1'b0);
        repeat ($urandom_range(3)) send_item(8'($urandom_range(255)), 1'b0);
      end else if (r < 90) begin
        // abandoned by the next first byte
        build_packet(1'b0);
        send_pkt($urandom_range(pkt.size() - 1, 1));
      end else begin
        repeat ($urandom_range(8, 1))
          send_item(8'($urandom_range(255)), $urandom_range(9) == 0);
      end
    end
  endtask

  // receiver holds off while dense packets keep coming, so the input stalls
  task automatic test_backpressure;
    send_pct = 0;
    recv_pct = 0;
    hold_tog <= ~hold_tog;
    repeat (3) begin
      build_packet(1'b1);
      send_pkt(pkt.size());
    end
  endtask

  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= HoldLen;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid_o && !out_stall) begin
      got.kind = kind_o;
      got.quat_i = quat_i_o;
      got.quat_j = quat_j_o;
      got.quat_k = quat_k_o;
      got.quat_real = quat_real_o;
      got.accuracy_q12 = accuracy_q12_o;
      got.any_found = any_found_o;
      got.last = last_o;
      if (due_items.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result item: kind=%0d", got.kind);
      end else begin
        want = due_items.pop_front();
        if (got.kind !== want.kind || got.quat_i !== want.quat_i ||
            got.quat_j !== want.quat_j || got.quat_k !== want.quat_k ||
            got.quat_real !== want.quat_real || got.accuracy_q12 !== want.accuracy_q12 ||
            got.any_found !== want.any_found || got.last !== want.last) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("mismatch exp: kind=%0d i=%0d j=%0d k=%0d r=%0d acc=%0d found=%0d last=%0d",
                     want.kind, want.quat_i, want.quat_j, want.quat_k, want.quat_real,
                     want.accuracy_q12, want.any_found, want.last);
            $display("         got: kind=%0d i=%0d j=%0d k=%0d r=%0d acc=%0d found=%0d last=%0d",
                     got.kind, got.quat_i, got.quat_j, got.quat_k, got.quat_real,
                     got.accuracy_q12, got.any_found, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LimitCycles) begin
      $display("[sensor_hub_report_parser_core] ERROR");
      $finish;
    end
  end

  initial begin
    byte_pos = '0;
    pkt_len = '0;
    len_low = '0;
    rec_start = '0;
    collecting = 1'b0;
    rot_bytes = '{default: 8'h00};
    seen_report = 1'b0;
    walk_stopped = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_and_short();
    test_restart();
    test_extreme_report();
    test_drain();
    test_random_traffic(22, 80, 450);
    test_backpressure();
    test_drain();
    test_random_traffic(80, 22, 450);
    test_random_traffic(0, 0, 400);
    test_drain();

    repeat (EndWait) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[sensor_hub_report_parser_core] OK");
    end else begin
      $display("[sensor_hub_report_parser_core] ERROR");
    end
    $finish;
  end

endmodule
